>>> rtl/core/snc_pkg.sv
package snc_pkg;

    localparam int MaxClips = 9;
    localparam int CodeW    = 4;
    localparam int LenW     = 4;
    localparam int AddrW    = 8;

    typedef logic [CodeW-1:0] clip_code_t;

    // clip codes beyond the digits share the digit table
    localparam clip_code_t CODE_ZERO     = 4'd0;
    localparam clip_code_t CODE_TEN      = 4'd10;
    localparam clip_code_t CODE_HOUR     = 4'd11;
    localparam clip_code_t CODE_MINUTE   = 4'd12;
    localparam clip_code_t CODE_DEGREE   = 4'd13;
    localparam clip_code_t CODE_TIME_PRE = 4'd14;
    localparam clip_code_t CODE_TEMP_PRE = 4'd15;

    localparam logic MODE_TIME = 1'b0;
    localparam logic MODE_TEMP = 1'b1;

    typedef struct packed {
        logic [LenW-1:0]                len;
        logic [MaxClips-1:0][CodeW-1:0] code;
    } script_t;

    function automatic logic [AddrW-1:0] clip_start_of(input clip_code_t c);
        logic [AddrW-1:0] r;
        case (c)
            4'd0:    r = 8'd96;
            4'd1:    r = 8'd1;
            4'd2:    r = 8'd6;
            4'd3:    r = 8'd11;
            4'd4:    r = 8'd16;
            4'd5:    r = 8'd21;
            4'd6:    r = 8'd26;
            4'd7:    r = 8'd31;
            4'd8:    r = 8'd36;
            4'd9:    r = 8'd41;
            4'd10:   r = 8'd46;
            4'd11:   r = 8'd51;
            4'd12:   r = 8'd56;
            4'd13:   r = 8'd61;
            4'd14:   r = 8'd66;
            default: r = 8'd81;
        endcase
        return r;
    endfunction

    function automatic logic [AddrW-1:0] clip_end_of(input clip_code_t c);
        logic [AddrW-1:0] r;
        case (c)
            4'd0:    r = 8'd100;
            4'd1:    r = 8'd5;
            4'd2:    r = 8'd10;
            4'd3:    r = 8'd15;
            4'd4:    r = 8'd20;
            4'd5:    r = 8'd25;
            4'd6:    r = 8'd30;
            4'd7:    r = 8'd35;
            4'd8:    r = 8'd40;
            4'd9:    r = 8'd45;
            4'd10:   r = 8'd50;
            4'd11:   r = 8'd55;
            4'd12:   r = 8'd60;
            4'd13:   r = 8'd65;
            4'd14:   r = 8'd80;
            default: r = 8'd95;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/spoken_number_clip_sequencer.sv
// the first clip of a request passes through the queue entry and then the output register
// each request gives 4 to 9 clips; the clip walker sends one clip per cycle while m_tready allows
// a queue of QUEUE_DEPTH requests sits ahead of the walker, so input keeps flowing until it fills
// reset: rst_n asynchronous active low, clears queue pointers and output valid
module spoken_number_clip_sequencer
    import snc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode, first_tens, first_units, second_tens, second_units
    // clip channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // clip_start, clip_end
    output logic        m_tlast    // last clip of the announcement
);

    script_t          req_script;
    script_t          q_head;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [AddrW-1:0] clip_start;
    logic [AddrW-1:0] clip_end;

    // front: turn the request into an ordered list of clip codes
    snc_front u_front
    (
        .mode         (s_tdata[0]),
        .first_tens   (s_tdata[4:1]),
        .first_units  (s_tdata[8:5]),
        .second_tens  (s_tdata[12:9]),
        .second_units (s_tdata[16:13]),
        .script       (req_script)
    );

    // a transfer lands straight in the queue
    assign s_tready = !q_full;

    snc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (req_script),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // back: walk the clip list, map codes to address ranges, hold in output register
    snc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_start (clip_start),
        .out_end   (clip_end),
        .out_last  (m_tlast)
    );

    assign m_tdata = {clip_end, clip_start};

endmodule

>>> rtl/core/snc_front.sv
module snc_front
    import snc_pkg::*;
(
    input  logic       mode,
    input  clip_code_t first_tens,
    input  clip_code_t first_units,
    input  clip_code_t second_tens,
    input  clip_code_t second_units,
    output script_t    script
);

    logic [LenW-1:0] pos;

    // builds the ordered clip list of one request
    always_comb
    begin
        script = '0;
        pos    = '0;
        if (mode == MODE_TIME)
        begin
            script.code[pos] = CODE_TIME_PRE;
            pos = pos + 4'd1;
            if (first_tens == CODE_ZERO)
            begin
                script.code[pos] = first_units;
                pos = pos + 4'd1;
            end
            else
            begin
                script.code[pos] = first_tens;
                pos = pos + 4'd1;
                script.code[pos] = CODE_TEN;
                pos = pos + 4'd1;
                if (first_units != CODE_ZERO)
                begin
                    script.code[pos] = first_units;
                    pos = pos + 4'd1;
                end
            end
            script.code[pos] = CODE_HOUR;
            pos = pos + 4'd1;
            if (second_tens == CODE_ZERO)
            begin
                script.code[pos] = second_units;
                pos = pos + 4'd1;
            end
            else
            begin
                script.code[pos] = second_tens;
                pos = pos + 4'd1;
                script.code[pos] = CODE_TEN;
                pos = pos + 4'd1;
                if (second_units != CODE_ZERO)
                begin
                    script.code[pos] = second_units;
                    pos = pos + 4'd1;
                end
            end
            script.code[pos] = CODE_MINUTE;
            pos = pos + 4'd1;
        end
        else
        begin
            script.code[pos] = CODE_TEMP_PRE;
            pos = pos + 4'd1;
            script.code[pos] = first_tens;
            pos = pos + 4'd1;
            script.code[pos] = CODE_TEN;
            pos = pos + 4'd1;
            if (first_units != CODE_ZERO)
            begin
                script.code[pos] = first_units;
                pos = pos + 4'd1;
            end
            script.code[pos] = CODE_DEGREE;
            pos = pos + 4'd1;
        end
        script.len = pos;
    end

endmodule

>>> rtl/core/snc_queue.sv
module snc_queue
    import snc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  script_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output script_t head
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    script_t           entry_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/snc_back.sv
module snc_back
    import snc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  script_t          q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [AddrW-1:0] out_start,
    output logic [AddrW-1:0] out_end,
    output logic             out_last
);

    logic [LenW-1:0]  idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [AddrW-1:0] start_reg, start_next;
    logic [AddrW-1:0] end_reg, end_next;
    logic             last_reg, last_next;
    logic             load;
    logic             at_last;
    clip_code_t       code;

    assign load    = q_valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == q_head.len - 4'd1);
    assign code    = q_head.code[idx_reg];
    assign q_pop   = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        start_next = start_reg;
        end_next   = end_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            start_next = clip_start_of(code);
            end_next   = clip_end_of(code);
            last_next  = at_last;
            idx_next   = at_last ? '0 : idx_reg + 4'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_start = start_reg;
    assign out_end   = end_reg;
    assign out_last  = last_reg;

endmodule

>>> tb/spoken_number_clip_sequencer_check.sv
module spoken_number_clip_sequencer_check
    import snc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // mode, first_tens, first_units, second_tens, second_units
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // clip_start, clip_end
    input  logic        m_tlast,   // last clip of the announcement
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [AddrW-1:0] first_addr;
        logic [AddrW-1:0] last_addr;
        logic             closing;
    } clip_t;

    clip_t expected_clips[$];
    clip_t announcement[$];

    // address range of one clip code
    function automatic void add_clip(input clip_code_t code);
        clip_t c;
        case (code)
            CODE_ZERO:
            begin
                c.first_addr = 8'd96;
                c.last_addr  = 8'd100;
            end
            CODE_TIME_PRE:
            begin
                c.first_addr = 8'd66;
                c.last_addr  = 8'd80;
            end
            CODE_TEMP_PRE:
            begin
                c.first_addr = 8'd81;
                c.last_addr  = 8'd95;
            end
            default:
            begin
                c.last_addr  = 8'(5 * code);
                c.first_addr = c.last_addr - 8'd4;
            end
        endcase
        c.closing = 1'b0;
        announcement.push_back(c);
    endfunction

    // zero tens speaks the units digit alone, even a zero
    function automatic void add_time_number(input clip_code_t tens, input clip_code_t units);
        if (tens == CODE_ZERO)
        begin
            add_clip(units);
        end
        else
        begin
            add_clip(tens);
            add_clip(CODE_TEN);
            if (units != CODE_ZERO)
                add_clip(units);
        end
    endfunction

    function automatic void predict_announcement(input logic [23:0] word);
        logic       mode;
        clip_code_t first_tens;
        clip_code_t first_units;
        clip_code_t second_tens;
        clip_code_t second_units;
        mode         = word[0];
        first_tens   = word[4:1];
        first_units  = word[8:5];
        second_tens  = word[12:9];
        second_units = word[16:13];
        announcement.delete();
        if (mode == MODE_TIME)
        begin
            add_clip(CODE_TIME_PRE);
            add_time_number(first_tens, first_units);
            add_clip(CODE_HOUR);
            add_time_number(second_tens, second_units);
            add_clip(CODE_MINUTE);
        end
        else
        begin
            add_clip(CODE_TEMP_PRE);
            add_clip(first_tens);
            add_clip(CODE_TEN);
            if (first_units != CODE_ZERO)
                add_clip(first_units);
            add_clip(CODE_DEGREE);
        end
        announcement[announcement.size() - 1].closing = 1'b1;
        foreach (announcement[i])
            expected_clips.push_back(announcement[i]);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t clip mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_clip();
        clip_t want;
        if (expected_clips.size() == 0)
        begin
            report_mismatch($sformatf("clip %0d..%0d with no request waiting",
                                      m_tdata[7:0], m_tdata[15:8]));
        end
        else
        begin
            want = expected_clips.pop_front();
            if (m_tdata[7:0] !== want.first_addr)
                report_mismatch($sformatf("clip_start got %0d want %0d",
                                          m_tdata[7:0], want.first_addr));
            if (m_tdata[15:8] !== want.last_addr)
                report_mismatch($sformatf("clip_end got %0d want %0d",
                                          m_tdata[15:8], want.last_addr));
            if (m_tlast !== want.closing)
                report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.closing));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            expected_clips.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_announcement(s_tdata);
            if (m_tvalid && m_tready)
                check_clip();
        end
        pending <= expected_clips.size();
    end

endmodule

>>> tb/spoken_number_clip_sequencer_test.sv
module spoken_number_clip_sequencer_test
    import snc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // longest stretch without any transfer before the run is called hung;
    // well above the forced receiver hold-off plus a long random stall
    localparam int QUIET_LIMIT     = 1000;
    // receiver hold-off used to fill the request queue and stall the input
    localparam int HOLD_OFF_CYCLES = 200;
    // settle time after the last clip, a few announcements' worth
    localparam int DRAIN_CYCLES    = 30;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // mode, first_tens, first_units, second_tens, second_units
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // clip_start, clip_end
    logic        m_tlast;         // last clip of the announcement

    int mismatches;
    int pending_clips;

    // idle percentages per cycle, changed between phases
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    // hold-off request from the stimulus, counted out by the receiver itself
    logic hold_off_wanted = 1'b0;
    int   hold_count      = 0;

    int quiet_cycles = 0;

    always #5 clk = ~clk;

    spoken_number_clip_sequencer DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // watches both channels, predicts the clip run of each request and compares
    spoken_number_clip_sequencer_check clip_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending_clips)
    );

    // clip receiver: a single long hold-off once asked, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_off_wanted && hold_count < HOLD_OFF_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // hang detection: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // request word, mode in bit 0 and the four digits above it
    function automatic logic [23:0] pack_request(input logic mode,
                                                 input clip_code_t first_tens,
                                                 input clip_code_t first_units,
                                                 input clip_code_t second_tens,
                                                 input clip_code_t second_units);
        return {7'b0, second_units, second_tens, first_units, first_tens, mode};
    endfunction

    // mostly legal digits, now and then a code from ten to fifteen
    function automatic clip_code_t random_digit();
        if ($urandom_range(99) < 88)
            return clip_code_t'($urandom_range(9));
        return clip_code_t'($urandom_range(15, 10));
    endfunction

    function automatic logic [23:0] random_request();
        return pack_request(1'($urandom_range(1)), random_digit(), random_digit(),
                            random_digit(), random_digit());
    endfunction

    // one request transfer; valid only drops when an idle cycle is drawn, so a
    // back-to-back request never lowers and raises it in the same step
    task automatic offer_request(input logic [23:0] word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender idles rarely, receiver mostly stalls
        sender_idle_pct   = 16;
        receiver_idle_pct = 85;

        // time: zero tens with zero units, zero tens alone, round tens, full phrases
        offer_request(pack_request(MODE_TIME, 4'd0, 4'd0, 4'd0, 4'd0));
        offer_request(pack_request(MODE_TIME, 4'd0, 4'd9, 4'd0, 4'd5));
        offer_request(pack_request(MODE_TIME, 4'd1, 4'd0, 4'd3, 4'd0));
        offer_request(pack_request(MODE_TIME, 4'd1, 4'd2, 4'd3, 4'd4));
        offer_request(pack_request(MODE_TIME, 4'd2, 4'd3, 4'd5, 4'd9));
        offer_request(pack_request(MODE_TIME, 4'd9, 4'd9, 4'd9, 4'd9));
        // longest announcement: nonzero tens and units on both numbers
        offer_request(pack_request(MODE_TIME, 4'd15, 4'd15, 4'd15, 4'd15));
        // out-of-range digit codes in every position
        offer_request(pack_request(MODE_TIME, 4'd10, 4'd11, 4'd12, 4'd13));
        offer_request(pack_request(MODE_TIME, 4'd14, 4'd15, 4'd0, 4'd14));
        offer_request(pack_request(MODE_TIME, 4'd0, 4'd10, 4'd13, 4'd0));
        // temperature: zero tens is still spoken, zero units is dropped
        offer_request(pack_request(MODE_TEMP, 4'd0, 4'd0, 4'd0, 4'd0));
        offer_request(pack_request(MODE_TEMP, 4'd0, 4'd5, 4'd0, 4'd0));
        offer_request(pack_request(MODE_TEMP, 4'd1, 4'd0, 4'd0, 4'd0));
        offer_request(pack_request(MODE_TEMP, 4'd9, 4'd9, 4'd0, 4'd0));
        // second digit pair must be ignored in temperature mode
        offer_request(pack_request(MODE_TEMP, 4'd2, 4'd7, 4'd15, 4'd15));
        offer_request(pack_request(MODE_TEMP, 4'd15, 4'd15, 4'd9, 4'd3));
        offer_request(pack_request(MODE_TEMP, 4'd10, 4'd14, 4'd0, 4'd0));
        offer_request(pack_request(MODE_TEMP, 4'd12, 4'd11, 4'd5, 4'd0));

        repeat (30) offer_request(random_request());

        // phase two: sender mostly idles, receiver rarely stalls
        sender_idle_pct   = 85;
        receiver_idle_pct = 16;
        repeat (30) offer_request(random_request());

        // phase three: no idling; the receiver holds off while requests keep
        // coming, so the queue fills and the input stalls
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_wanted   = 1'b1;
        repeat (32) offer_request(random_request());

        s_tvalid <= 1'b0;
        // let the last transfer reach the expectation count before polling it
        @(posedge clk);
        while (pending_clips != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_clips == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
